// ===== rtl/reference_trajectory_generator_unit_defines.svh =====
// Assertion macros shared by the reference trajectory generator RTL.
// Included by the files that carry concurrent checks; no other dependencies.
`ifndef REFERENCE_TRAJECTORY_GENERATOR_UNIT_DEFINES_SVH
`define REFERENCE_TRAJECTORY_GENERATOR_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define RTG_ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication check failed");
`define RTG_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication check failed");
`else
`define RTG_ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define RTG_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/rtg_pkg.sv =====
// Shared types, codes and helper functions of the reference trajectory generator.
// No dependencies; rtg_front, rtg_back and the top level import this package.
`default_nettype none
package rtg_pkg;

   localparam int TABLE_DEPTH_DEF    = 1024;
   localparam int SINE_ROM_DEPTH_DEF = 256;
   localparam int QUEUE_DEPTH        = 2;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_MODE          = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_AMPLITUDE     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PHASE_STEP    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_STEP_DELAY    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_TABLE_LENGTH  = 3'd4;

   localparam logic [1:0] FUNC_TICK     = 2'd0;
   localparam logic [1:0] FUNC_TABLE_WR = 2'd1;
   localparam logic [1:0] FUNC_COEF_WR  = 2'd2;
   localparam logic [1:0] FUNC_CLEAR    = 2'd3;

   localparam logic [2:0] MODE_ZERO  = 3'd0;
   localparam logic [2:0] MODE_CONST = 3'd1;
   localparam logic [2:0] MODE_SINE  = 3'd2;
   localparam logic [2:0] MODE_FILT  = 3'd3;
   localparam logic [2:0] MODE_STEP  = 3'd4;
   localparam logic [2:0] MODE_TABLE = 3'd5;

   localparam int NUM_COEFS = 9;
   localparam int COEF_W    = 4;
   localparam logic [COEF_W-1:0] COEF_A11 = 4'd0;
   localparam logic [COEF_W-1:0] COEF_A12 = 4'd1;
   localparam logic [COEF_W-1:0] COEF_A21 = 4'd2;
   localparam logic [COEF_W-1:0] COEF_A22 = 4'd3;
   localparam logic [COEF_W-1:0] COEF_B1  = 4'd4;
   localparam logic [COEF_W-1:0] COEF_B2  = 4'd5;
   localparam logic [COEF_W-1:0] COEF_C1  = 4'd6;
   localparam logic [COEF_W-1:0] COEF_C2  = 4'd7;
   localparam logic [COEF_W-1:0] COEF_D   = 4'd8;

   typedef enum logic [1:0] {OP_TICK, OP_TABLE_WR, OP_COEF_WR, OP_CLEAR} op_type;

   typedef struct packed {
      op_type             op;
      logic [9:0]         index;
      logic signed [15:0] value;
   } queue_entry_type;

   typedef struct packed {
      logic [2:0]         mode;
      logic signed [15:0] amplitude;
      logic [31:0]        phase_step;
      logic [31:0]        step_delay_ticks;
      logic [10:0]        table_length;
   } config_type;

   typedef enum logic [2:0] {
      BK_IDLE, BK_PHASE, BK_ROM, BK_SINE, BK_TABLE, BK_SCALE, BK_FILT
   } back_state_type;

   function automatic logic signed [15:0] sat16(input logic signed [49:0] x);
      if (x > 50'sd32767) return 16'sh7FFF;
      if (x < -50'sd32768) return 16'sh8000;
      return x[15:0];
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [49:0] x);
      if (x > 50'sd2147483647) return 32'sh7FFF_FFFF;
      if (x < -50'sd2147483648) return 32'sh8000_0000;
      return x[31:0];
   endfunction

   // Filter product order: output row, then first state row, then second state row.
   function automatic logic [COEF_W-1:0] term_coef(input logic [3:0] t);
      case (t)
         4'd0: return COEF_C1;
         4'd1: return COEF_C2;
         4'd2: return COEF_D;
         4'd3: return COEF_A11;
         4'd4: return COEF_A12;
         4'd5: return COEF_B1;
         4'd6: return COEF_A21;
         4'd7: return COEF_A22;
         4'd8: return COEF_B2;
         default: return COEF_C1;
      endcase
   endfunction

   // Position within a row: 0 first state, 1 second state, 2 input.
   function automatic logic [1:0] term_pos(input logic [3:0] t);
      case (t)
         4'd0, 4'd3, 4'd6: return 2'd0;
         4'd1, 4'd4, 4'd7: return 2'd1;
         default:          return 2'd2;
      endcase
   endfunction

   function automatic logic [1:0] term_group(input logic [3:0] t);
      case (t)
         4'd0, 4'd1, 4'd2: return 2'd0;
         4'd3, 4'd4, 4'd5: return 2'd1;
         default:          return 2'd2;
      endcase
   endfunction

endpackage
`default_nettype wire

// ===== rtl/rtg_if.sv =====
// Valid/ready channel interfaces for the request and response sides.
// Depends on nothing but the language; used by the top level and its children.
`default_nettype none
interface rtg_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         func;
   logic [9:0]         index;
   logic signed [15:0] value;
   modport source (output valid, func, index, value, input ready);
   modport sink   (input valid, func, index, value, output ready);
endinterface

interface rtg_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] reference;
   modport source (output valid, reference, input ready);
   modport sink   (input valid, reference, output ready);
endinterface
`default_nettype wire

// ===== rtl/rtg_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none
module rtg_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

// ===== rtl/rtg_front.sv =====
// Front end: accepts request items, drops writes that address nothing, and queues the rest.
// Depends on rtg_pkg and rtg_req_if.
`default_nettype none
module rtg_front
   import rtg_pkg::*;
#(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
   input  wire logic      clock,
   input  wire logic      reset,
   rtg_req_if.sink        req_ch,
   output queue_entry_type head,
   output logic           head_valid,
   input  wire logic      head_pop
);
   localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCW = $clog2(QUEUE_DEPTH + 1);

   queue_entry_type entries_ff [QUEUE_DEPTH];
   logic [QAW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QAW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCW-1:0]  count_ff, count_in;
   queue_entry_type incoming;
   logic            keep;
   logic            push;
   logic            pop;

   always_comb begin
      incoming.index = req_ch.index;
      incoming.value = req_ch.value;
      case (req_ch.func)
         FUNC_TICK: begin
            incoming.op = OP_TICK;
            keep        = 1'b1;
         end
         FUNC_TABLE_WR: begin
            incoming.op = OP_TABLE_WR;
            keep        = (32'(req_ch.index) < TABLE_DEPTH);
         end
         FUNC_COEF_WR: begin
            incoming.op = OP_COEF_WR;
            keep        = (32'(req_ch.index) < NUM_COEFS);
         end
         FUNC_CLEAR: begin
            incoming.op = OP_CLEAR;
            keep        = 1'b1;
         end
         default: begin
            incoming.op = OP_TICK;
            keep        = 1'b1;
         end
      endcase
   end

   assign req_ch.ready = (count_ff != QCW'(QUEUE_DEPTH));
   assign push = req_ch.valid && req_ch.ready && keep;
   assign pop  = head_pop && head_valid;
   assign head_valid = (count_ff != '0);
   assign head = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QAW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QAW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= incoming;
      end
   end
endmodule
`default_nettype wire

// ===== rtl/rtg_back.sv =====
// Back end: executes queued items, holds the generator state and the shared multiplier.
// Depends on rtg_pkg, rtg_rsp_if, rtg_ram and the assertion macro header.
`default_nettype none
`include "reference_trajectory_generator_unit_defines.svh"
module rtg_back
   import rtg_pkg::*;
#(
   parameter int TABLE_DEPTH    = TABLE_DEPTH_DEF,
   parameter int SINE_ROM_DEPTH = SINE_ROM_DEPTH_DEF
) (
   input  wire logic      clock,
   input  wire logic      reset,
   input  config_type     cfg,
   input  queue_entry_type head,
   input  wire logic      head_valid,
   output logic           head_pop,
   rtg_rsp_if.source      rsp_ch
);
   localparam int TAW = $clog2(TABLE_DEPTH);
   localparam int RAW = $clog2(SINE_ROM_DEPTH + 1);
   localparam logic [RAW-1:0] ROM_D   = RAW'(SINE_ROM_DEPTH);
   localparam logic [16:0]    DEPTH17 = 17'(TABLE_DEPTH);

   // Quarter-wave sine table, built at elaboration with a seven-term Taylor series.
   logic [14:0] sine_rom [SINE_ROM_DEPTH + 1];
   for (genvar k = 0; k <= SINE_ROM_DEPTH; k++) begin : g_rom
      localparam logic [63:0] X  = (64'(k) * HALF_PI_Q30) / SINE_ROM_DEPTH;
      localparam logic [63:0] T1 = ((((X  * X) >> 30) * X) >> 30) / 6;
      localparam logic [63:0] T2 = ((((T1 * X) >> 30) * X) >> 30) / 20;
      localparam logic [63:0] T3 = ((((T2 * X) >> 30) * X) >> 30) / 42;
      localparam logic [63:0] T4 = ((((T3 * X) >> 30) * X) >> 30) / 72;
      localparam logic [63:0] T5 = ((((T4 * X) >> 30) * X) >> 30) / 110;
      localparam logic [63:0] T6 = ((((T5 * X) >> 30) * X) >> 30) / 156;
      localparam logic signed [63:0] SUM = $signed(X) - $signed(T1) + $signed(T2)
         - $signed(T3) + $signed(T4) - $signed(T5) + $signed(T6);
      localparam logic [63:0] SUMC = SUM[63] ? 64'd0 : SUM;
      localparam logic [63:0] E = (SUMC * 64'd32767 + 64'd536870912) >> 30;
      assign sine_rom[k] = (E > 64'd32767) ? 15'd32767 : E[14:0];
   end

   back_state_type      state_ff, state_in;
   logic [31:0]         tick_ff, tick_in;
   logic [TAW-1:0]      pos_ff, pos_in;
   logic signed [31:0]  x0_ff, x0_in;
   logic signed [31:0]  x1_ff, x1_in;
   logic signed [31:0]  newx0_ff, newx0_in;
   logic signed [15:0]  coef_ff [NUM_COEFS];
   logic signed [15:0]  coef_in [NUM_COEFS];
   logic [31:0]         phase_ff, phase_in;
   logic [RAW-1:0]      rom_addr_ff, rom_addr_in;
   logic                neg_ff, neg_in;
   logic [14:0]         rom_q_ff, rom_q_in;
   logic signed [47:0]  prod_ff, prod_in;
   logic                pv_ff, pv_in;
   logic [3:0]          pterm_ff, pterm_in;
   logic [3:0]          term_ff, term_in;
   logic signed [49:0]  acc_ff, acc_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic signed [15:0]  rsp_ref_ff, rsp_ref_in;

   logic signed [15:0]  mult_a;
   logic signed [31:0]  mult_b;
   logic signed [47:0]  mult_p;
   logic                ram_we;
   logic                ram_re;
   logic [15:0]         ram_rdata;
   logic [29+RAW:0]     idx_prod;
   logic [RAW-1:0]      rom_i;
   logic [16:0]         len_c;
   logic                pos_last;
   logic signed [49:0]  scaled;
   logic signed [49:0]  base;
   logic signed [49:0]  sum;
   logic [1:0]          grp;
   logic [1:0]          tpos;

   assign mult_p = mult_a * mult_b;

   rtg_ram #(.WIDTH(16), .DEPTH(TABLE_DEPTH)) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (TAW'(head.index)),
      .wr_data (head.value),
      .rd_en   (ram_re),
      .rd_addr (pos_ff),
      .rd_data (ram_rdata)
   );

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.reference = rsp_ref_ff;

   always_comb begin
      state_in     = state_ff;
      tick_in      = tick_ff;
      pos_in       = pos_ff;
      x0_in        = x0_ff;
      x1_in        = x1_ff;
      newx0_in     = newx0_ff;
      coef_in      = coef_ff;
      phase_in     = phase_ff;
      rom_addr_in  = rom_addr_ff;
      neg_in       = neg_ff;
      rom_q_in     = rom_q_ff;
      prod_in      = prod_ff;
      pv_in        = pv_ff;
      pterm_in     = pterm_ff;
      term_in      = term_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_ref_in   = rsp_ref_ff;
      head_pop     = 1'b0;
      ram_we       = 1'b0;
      ram_re       = 1'b0;
      mult_a       = cfg.amplitude;
      mult_b       = '0;

      len_c = (cfg.table_length == '0) ? 17'd1
            : ((17'(cfg.table_length) > DEPTH17) ? DEPTH17 : 17'(cfg.table_length));
      pos_last = (17'(pos_ff) >= (len_c - 17'd1));
      idx_prod = phase_ff[29:0] * ROM_D;
      rom_i    = idx_prod[29+RAW:30];
      scaled   = (50'(prod_ff) + 50'sd16384) >>> 15;
      grp      = term_group(pterm_ff);
      tpos     = term_pos(pterm_ff);
      base     = (tpos != 2'd0) ? acc_ff
               : ((grp == 2'd0) ? 50'sd2097152 : 50'sd8192);
      sum      = base + 50'(prod_ff);

      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         BK_IDLE: begin
            if (head_valid) begin
               case (head.op)
                  OP_TABLE_WR: begin
                     head_pop = 1'b1;
                     ram_we   = 1'b1;
                  end
                  OP_COEF_WR: begin
                     head_pop = 1'b1;
                     coef_in[head.index[COEF_W-1:0]] = head.value;
                  end
                  OP_CLEAR: begin
                     head_pop = 1'b1;
                     x0_in    = '0;
                     x1_in    = '0;
                     tick_in  = '0;
                  end
                  OP_TICK: begin
                     if (!rsp_valid_ff) begin
                        head_pop = 1'b1;
                        case (cfg.mode)
                           MODE_CONST: begin
                              rsp_valid_in = 1'b1;
                              rsp_ref_in   = cfg.amplitude;
                           end
                           MODE_SINE: begin
                              phase_in = tick_ff * cfg.phase_step;
                              tick_in  = tick_ff + 32'd1;
                              state_in = BK_PHASE;
                           end
                           MODE_FILT: begin
                              term_in  = '0;
                              pv_in    = 1'b0;
                              state_in = BK_FILT;
                           end
                           MODE_STEP: begin
                              rsp_valid_in = 1'b1;
                              rsp_ref_in   = (tick_ff < cfg.step_delay_ticks) ? '0
                                           : cfg.amplitude;
                              if (tick_ff != 32'hFFFF_FFFF) begin
                                 tick_in = tick_ff + 32'd1;
                              end
                           end
                           MODE_TABLE: begin
                              ram_re   = 1'b1;
                              pos_in   = pos_last ? '0 : pos_ff + 1'b1;
                              state_in = BK_TABLE;
                           end
                           default: begin
                              rsp_valid_in = 1'b1;
                              rsp_ref_in   = '0;
                           end
                        endcase
                     end
                  end
                  default: ;
               endcase
            end
         end
         BK_PHASE: begin
            rom_addr_in = phase_ff[30] ? (ROM_D - rom_i) : rom_i;
            neg_in      = phase_ff[31];
            state_in    = BK_ROM;
         end
         BK_ROM: begin
            rom_q_in = sine_rom[rom_addr_ff];
            state_in = BK_SINE;
         end
         BK_SINE: begin
            mult_b   = neg_ff ? -32'(rom_q_ff) : 32'(rom_q_ff);
            prod_in  = mult_p;
            state_in = BK_SCALE;
         end
         BK_TABLE: begin
            mult_b   = 32'($signed(ram_rdata));
            prod_in  = mult_p;
            state_in = BK_SCALE;
         end
         BK_SCALE: begin
            rsp_valid_in = 1'b1;
            rsp_ref_in   = sat16(scaled);
            state_in     = BK_IDLE;
         end
         BK_FILT: begin
            // Issue one product per cycle; accumulate it the cycle after.
            if (term_ff < 4'(NUM_COEFS)) begin
               mult_a = coef_ff[term_coef(term_ff)];
               case (term_pos(term_ff))
                  2'd0:    mult_b = x0_ff;
                  2'd1:    mult_b = x1_ff;
                  default: mult_b = {{8{cfg.amplitude[15]}}, cfg.amplitude, 8'd0};
               endcase
               prod_in  = mult_p;
               pv_in    = 1'b1;
               pterm_in = term_ff;
               term_in  = term_ff + 4'd1;
            end else begin
               pv_in = 1'b0;
            end
            if (pv_ff) begin
               if (tpos != 2'd2) begin
                  acc_in = sum;
               end else begin
                  case (grp)
                     2'd0: rsp_ref_in = sat16(sum >>> 22);
                     2'd1: newx0_in   = sat32(sum >>> 14);
                     default: begin
                        x0_in        = newx0_ff;
                        x1_in        = sat32(sum >>> 14);
                        rsp_valid_in = 1'b1;
                        pv_in        = 1'b0;
                        state_in     = BK_IDLE;
                     end
                  endcase
               end
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         tick_ff      <= '0;
         pos_ff       <= '0;
         x0_ff        <= '0;
         x1_ff        <= '0;
         for (int i = 0; i < NUM_COEFS; i++) begin
            coef_ff[i] <= '0;
         end
         pv_ff        <= 1'b0;
         term_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tick_ff      <= tick_in;
         pos_ff       <= pos_in;
         x0_ff        <= x0_in;
         x1_ff        <= x1_in;
         coef_ff      <= coef_in;
         pv_ff        <= pv_in;
         term_ff      <= term_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      newx0_ff    <= newx0_in;
      phase_ff    <= phase_in;
      rom_addr_ff <= rom_addr_in;
      neg_ff      <= neg_in;
      rom_q_ff    <= rom_q_in;
      prod_ff     <= prod_in;
      pterm_ff    <= pterm_in;
      acc_ff      <= acc_in;
      rsp_ref_ff  <= rsp_ref_in;
   end

   `RTG_ASSERT_IMPLIES(a_tick_needs_free_slot, clock, reset, head_pop && head.op == OP_TICK, !rsp_valid_ff)
   `RTG_ASSERT_IMPLIES(a_pop_only_when_idle, clock, reset, state_ff != BK_IDLE, !head_pop)
   `RTG_ASSERT_NEXT(a_filter_ends_in_result, clock, reset, state_ff == BK_FILT && pv_ff && pterm_ff == 4'(NUM_COEFS - 1), rsp_valid_ff && state_ff == BK_IDLE)
endmodule
`default_nettype wire

// ===== rtl/reference_trajectory_generator_unit.sv =====
// Top level of the reference trajectory generator: configuration registers, front and back end.
// Depends on rtg_pkg, rtg_if, rtg_front and rtg_back.
`default_nettype none
// Each tick item on the request channel yields one reference item on the response
// channel; table writes, coefficient writes and clears yield nothing. The front end
// queues up to two items, so requests keep flowing while the back end works or while
// a finished reference waits to be taken. In the back end a write or clear, and a tick
// in the zero, constant and delayed-step modes, is handled in the idle state alone; a
// playback tick goes through table RAM read, scaling multiply and rounding, a sine tick
// through phase multiply, ROM address, ROM read, scaling multiply and rounding, and a
// filtered tick through the nine filter products, going one per cycle
// through the single 16 by 32 bit multiplier. A tick starts only once the previous
// reference item has been taken. Configuration is written through the csr port; the
// user must write it only while the block is idle, which the block itself does not
// enforce. There is no clearing pass after reset, and table entries hold no defined value until they are written.
module reference_trajectory_generator_unit
   import rtg_pkg::*;
#(
   parameter int TABLE_DEPTH    = TABLE_DEPTH_DEF,
   parameter int SINE_ROM_DEPTH = SINE_ROM_DEPTH_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   rtg_req_if.sink                     req_ch,
   rtg_rsp_if.source                   rsp_ch,
   input  wire logic                   csr_write_en,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_write_data
);
   config_type      cfg_ff, cfg_in;
   queue_entry_type head;
   logic            head_valid;
   logic            head_pop;

   // Register writes; an index past the last register is ignored.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_MODE:         cfg_in.mode             = csr_write_data[2:0];
            CSR_AMPLITUDE:    cfg_in.amplitude        = csr_write_data[15:0];
            CSR_PHASE_STEP:   cfg_in.phase_step       = csr_write_data;
            CSR_STEP_DELAY:   cfg_in.step_delay_ticks = csr_write_data;
            CSR_TABLE_LENGTH: cfg_in.table_length     = csr_write_data[10:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode             <= MODE_ZERO;
         cfg_ff.amplitude        <= '0;
         cfg_ff.phase_step       <= '0;
         cfg_ff.step_delay_ticks <= '0;
         cfg_ff.table_length     <= 11'd1024;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The front end classifies items and drops writes to nonexistent entries.
   rtg_front #(.TABLE_DEPTH(TABLE_DEPTH)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .head       (head),
      .head_valid (head_valid),
      .head_pop   (head_pop)
   );

   // The back end runs each queued item and owns the output register.
   rtg_back #(
      .TABLE_DEPTH    (TABLE_DEPTH),
      .SINE_ROM_DEPTH (SINE_ROM_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head       (head),
      .head_valid (head_valid),
      .head_pop   (head_pop),
      .rsp_ch     (rsp_ch)
   );
endmodule
`default_nettype wire
